// ----- hdl/spce_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spce_pkg
// Shared types and constants of the servo PWM command encoder.
// ----------------------------------------------------------------------------
package spce_pkg;

    localparam int CHANNELS  = 16;
    localparam int LED0_ADDR = 6;

    // Request kinds; the unused code is an error
    typedef enum logic [1:0] {
        REQ_DUTY  = 2'd0,
        REQ_PULSE = 2'd1,
        REQ_ANGLE = 2'd2
    } spce_req_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_FREQ      = 2'd0,
        CFG_MIN_PULSE = 2'd1,
        CFG_MAX_PULSE = 2'd2,
        CFG_MAX_ANGLE = 2'd3
    } spce_cfg_t;

    localparam logic [10:0] FREQ_MIN  = 11'd24;
    localparam logic [10:0] FREQ_MAX  = 11'd1526;
    localparam logic [11:0] DUTY_MAX  = 12'd4095;
    localparam logic [12:0] COUNT_FULL = 13'd4096;

    // ticks = floor((256*m + 500000) / 1e6) = floor((4*m + 7812) / 15625)
    localparam logic [25:0] TICK_BIAS  = 26'd7812;
    // h * TICK_RECIP >> TICK_SHIFT equals floor(h / 15625) for every h below 2^26
    localparam logic [26:0] TICK_RECIP = 27'd70368745;
    localparam int          TICK_SHIFT = 40;
    // 256*m >= 4095e6 exactly when m reaches this value
    localparam logic [30:0] TICK_SAT  = 31'd15996094;

    // Carried alongside the angle division
    typedef struct packed {
        logic        err;
        logic        is_duty;
        logic        is_angle;
        logic [7:0]  base_addr;
        logic [12:0] duty_on;
        logic [12:0] duty_off;
        logic [19:0] pulse;
    } spce_side_t;

    // Carried alongside the tick stages
    typedef struct packed {
        logic        err;
        logic        is_duty;
        logic        sat;
        logic [7:0]  base_addr;
        logic [12:0] duty_on;
        logic [12:0] duty_off;
    } spce_tail_t;

endpackage

// ----- hdl/spce_div_pipe.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spce_div_pipe
// Restoring divider, one quotient bit per register stage, with sideband.
// The upper DIVIDEND_W-QUOT_W bits of the dividend must be below the divisor.
// ----------------------------------------------------------------------------
module spce_div_pipe #(
    parameter int DIVIDEND_W = 36,
    parameter int DIVISOR_W  = 16,
    parameter int QUOT_W     = 20,
    parameter int SIDE_W     = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    input  logic [SIDE_W-1:0]     side_in,
    output logic                  out_valid,
    output logic [QUOT_W-1:0]     quotient,
    output logic [SIDE_W-1:0]     side_out
);

    localparam int W = DIVISOR_W + QUOT_W;

    logic              valid_reg [0:QUOT_W-1];
    logic [W-1:0]      w_reg     [0:QUOT_W-1];
    logic [SIDE_W-1:0] side_reg  [0:QUOT_W-1];

    // Shift in one dividend bit, subtract the divisor where it fits
    function automatic logic [W-1:0] div_step(input logic [W-1:0] w,
                                              input logic [DIVISOR_W-1:0] d);
        logic [W:0]         sh;
        logic [DIVISOR_W:0] top;
        logic               qbit;
        sh   = {w, 1'b0};
        top  = sh[W:QUOT_W];
        qbit = (top >= {1'b0, d});
        if (qbit) begin
            top = top - {1'b0, d};
        end
        return {top[DIVISOR_W-1:0], sh[QUOT_W-1:1], qbit};
    endfunction

    for (genvar i = 0; i < QUOT_W; i++) begin : g_stage
        logic              v_src;
        logic [W-1:0]      w_src;
        logic [SIDE_W-1:0] s_src;

        if (i == 0) begin : g_first
            assign v_src = in_valid;
            assign w_src = W'(dividend);
            assign s_src = side_in;
        end else begin : g_rest
            assign v_src = valid_reg[i-1];
            assign w_src = w_reg[i-1];
            assign s_src = side_reg[i-1];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[i] <= 1'b0;
            end else if (en) begin
                valid_reg[i] <= v_src;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                w_reg[i]    <= div_step(w_src, divisor);
                side_reg[i] <= s_src;
            end
        end
    end

    assign out_valid = valid_reg[QUOT_W-1];
    assign quotient  = w_reg[QUOT_W-1][QUOT_W-1:0];
    assign side_out  = side_reg[QUOT_W-1];

endmodule

// ----- hdl/servo_pwm_command_encoder_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// servo_pwm_command_encoder_core
// Channel command to on/off counts and base register address for a 12-bit
// PWM controller (duty, pulse width and angle requests).
// ----------------------------------------------------------------------------
// Takes one command per clock while s_tready is high and returns one result
// per command, in order. A command passes through one input stage, the angle
// multiply, a 20-stage divider for the angle interpolation, the pulse select,
// the frequency multiply, the tick scaling, a reciprocal multiply for the tick
// rounding, and the output register. Every request kind takes the same path.
// A skid register behind the output keeps s_tready registered; s_tready drops
// only while the skid register is full. Write configuration only while no
// command is in flight.
// ----------------------------------------------------------------------------
module servo_pwm_command_encoder_core (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [19:0] cfg_data,
    // commands
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // channel[7:0], duty[23:8], invert[24],
                                   // pulse[44:25], angle[61:45], zero[63:62]
    input  logic [1:0]  s_tuser,   // req_type[1:0]
    // results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // base_addr[7:0], on_count[20:8],
                                   // off_count[33:21], zero[39:34]
    output logic [0:0]  m_tuser    // status[0]
);

    // ---------------- configuration ----------------
    logic [10:0] freq_reg;
    logic [19:0] min_pulse_reg;
    logic [19:0] max_pulse_reg;
    logic [15:0] max_angle_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            freq_reg      <= 11'd50;
            min_pulse_reg <= 20'd8000;
            max_pulse_reg <= 20'd40000;
            max_angle_reg <= 16'd18000;
        end else if (cfg_valid) begin
            case (spce_pkg::spce_cfg_t'(cfg_index))
                spce_pkg::CFG_FREQ:      freq_reg      <= cfg_data[10:0];
                spce_pkg::CFG_MIN_PULSE: min_pulse_reg <= cfg_data;
                spce_pkg::CFG_MAX_PULSE: max_pulse_reg <= cfg_data;
                spce_pkg::CFG_MAX_ANGLE: max_angle_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    logic [19:0] pulse_span;
    logic [10:0] freq_sat;
    logic        angle_cfg_bad;

    assign pulse_span    = max_pulse_reg - min_pulse_reg;
    assign angle_cfg_bad = (max_angle_reg == 16'd0) || (max_pulse_reg < min_pulse_reg);

    always_comb begin
        freq_sat = freq_reg;
        if (freq_reg < spce_pkg::FREQ_MIN) begin
            freq_sat = spce_pkg::FREQ_MIN;
        end else if (freq_reg > spce_pkg::FREQ_MAX) begin
            freq_sat = spce_pkg::FREQ_MAX;
        end
    end

    // ---------------- flow control ----------------
    logic        en;
    logic        skid_valid_reg;
    logic [39:0] skid_data_reg;
    logic        skid_status_reg;
    logic        m_tvalid_reg;
    logic [39:0] m_tdata_reg;
    logic        m_tuser_reg;

    // the whole pipeline moves together while the skid register is empty
    assign en       = !skid_valid_reg;
    assign s_tready = en;

    // ---------------- stage 1: decode ----------------
    logic [7:0]  in_channel;
    logic [15:0] in_duty;
    logic        in_invert;
    logic [19:0] in_pulse;
    logic [16:0] in_angle;

    assign in_channel = s_tdata[7:0];
    assign in_duty    = s_tdata[23:8];
    assign in_invert  = s_tdata[24];
    assign in_pulse   = s_tdata[44:25];
    assign in_angle   = s_tdata[61:45];

    spce_pkg::spce_side_t side1_next;
    logic [15:0]          angle1_next;
    logic [11:0]          duty_c;

    always_comb begin
        side1_next           = '0;
        side1_next.base_addr = 8'(spce_pkg::LED0_ADDR) + {in_channel[5:0], 2'b00};
        side1_next.pulse     = in_pulse;
        duty_c = (in_duty > 16'(spce_pkg::DUTY_MAX)) ? spce_pkg::DUTY_MAX : in_duty[11:0];

        case (spce_pkg::spce_req_t'(s_tuser))
            spce_pkg::REQ_DUTY: begin
                side1_next.is_duty = 1'b1;
            end
            spce_pkg::REQ_PULSE: begin
                side1_next.is_duty = 1'b0;
            end
            spce_pkg::REQ_ANGLE: begin
                side1_next.is_angle = 1'b1;
                side1_next.err      = angle_cfg_bad;
            end
            default: begin
                side1_next.err = 1'b1;
            end
        endcase
        if (in_channel >= 8'(spce_pkg::CHANNELS)) begin
            side1_next.err = 1'b1;
        end

        // full-off and full-on encodings at the ends, swapped by invert
        if (duty_c == 12'd0) begin
            side1_next.duty_on  = in_invert ? spce_pkg::COUNT_FULL : 13'd0;
            side1_next.duty_off = in_invert ? 13'd0 : spce_pkg::COUNT_FULL;
        end else if (duty_c == spce_pkg::DUTY_MAX) begin
            side1_next.duty_on  = in_invert ? 13'd0 : spce_pkg::COUNT_FULL;
            side1_next.duty_off = in_invert ? spce_pkg::COUNT_FULL : 13'd0;
        end else begin
            side1_next.duty_on  = 13'd0;
            side1_next.duty_off = {1'b0, in_invert ? (spce_pkg::DUTY_MAX - duty_c) : duty_c};
        end

        // negative angles clamp to zero, large ones to the maximum
        if (in_angle[16]) begin
            angle1_next = 16'd0;
        end else if (in_angle[15:0] > max_angle_reg) begin
            angle1_next = max_angle_reg;
        end else begin
            angle1_next = in_angle[15:0];
        end
    end

    logic                 v1_reg;
    spce_pkg::spce_side_t side1_reg;
    logic [15:0]          angle1_reg;

    // ---------------- stage 2: angle times pulse span ----------------
    logic                 v2_reg;
    spce_pkg::spce_side_t side2_reg;
    logic [35:0]          prod2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side1_reg  <= side1_next;
            angle1_reg <= angle1_next;
            side2_reg  <= side1_reg;
            prod2_reg  <= 36'(angle1_reg) * 36'(pulse_span);
        end
    end

    // ---------------- angle division ----------------
    logic                 vq_a;
    logic [19:0]          quot_a;
    spce_pkg::spce_side_t side_a;

    spce_div_pipe #(
        .DIVIDEND_W (36),
        .DIVISOR_W  (16),
        .QUOT_W     (20),
        .SIDE_W     ($bits(spce_pkg::spce_side_t))
    ) u_angle_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v2_reg),
        .dividend  (prod2_reg),
        .divisor   (max_angle_reg),
        .side_in   (side2_reg),
        .out_valid (vq_a),
        .quotient  (quot_a),
        .side_out  (side_a)
    );

    // ---------------- stages 3 to 6: pulse select, frequency, scaling, rounding ----
    spce_pkg::spce_tail_t tail3_next;

    always_comb begin
        tail3_next           = '0;
        tail3_next.err       = side_a.err;
        tail3_next.is_duty   = side_a.is_duty;
        tail3_next.base_addr = side_a.base_addr;
        tail3_next.duty_on   = side_a.duty_on;
        tail3_next.duty_off  = side_a.duty_off;
    end

    logic                 v3_reg;
    spce_pkg::spce_tail_t tail3_reg;
    logic [19:0]          pulse3_reg;
    logic                 v4_reg;
    spce_pkg::spce_tail_t tail4_reg;
    logic [30:0]          m4_reg;
    logic                 v5_reg;
    spce_pkg::spce_tail_t tail5_reg;
    logic [25:0]          x5_reg;
    logic                 v6_reg;
    spce_pkg::spce_tail_t tail6_reg;
    logic [52:0]          prod6_reg;

    spce_pkg::spce_tail_t tail5_next;

    always_comb begin
        tail5_next     = tail4_reg;
        tail5_next.sat = (m4_reg >= spce_pkg::TICK_SAT);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= vq_a;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            tail3_reg  <= tail3_next;
            pulse3_reg <= side_a.is_angle ? (min_pulse_reg + quot_a) : side_a.pulse;
            tail4_reg  <= tail3_reg;
            m4_reg     <= 31'(pulse3_reg) * 31'(freq_sat);
            tail5_reg  <= tail5_next;
            // only meaningful below saturation, where m fits in 24 bits
            x5_reg     <= {m4_reg[23:0], 2'b00} + spce_pkg::TICK_BIAS;
            tail6_reg  <= tail5_reg;
            prod6_reg  <= 53'(x5_reg) * 53'(spce_pkg::TICK_RECIP);
        end
    end

    logic                 vq_t;
    logic [11:0]          quot_t;
    spce_pkg::spce_tail_t tail_t;

    assign vq_t   = v6_reg;
    assign quot_t = prod6_reg[spce_pkg::TICK_SHIFT+11:spce_pkg::TICK_SHIFT];
    assign tail_t = tail6_reg;

    // ---------------- result assembly ----------------
    logic [11:0] ticks;
    logic [12:0] res_on;
    logic [12:0] res_off;
    logic [7:0]  res_addr;
    logic [39:0] res_data;

    always_comb begin
        ticks    = tail_t.sat ? spce_pkg::DUTY_MAX : quot_t;
        res_on   = tail_t.is_duty ? tail_t.duty_on : 13'd0;
        res_off  = tail_t.is_duty ? tail_t.duty_off : {1'b0, ticks};
        res_addr = tail_t.base_addr;
        if (tail_t.err) begin
            res_on   = 13'd0;
            res_off  = 13'd0;
            res_addr = 8'd0;
        end
        res_data = {6'b000000, res_off, res_on, res_addr};
    end

    // ---------------- output register and skid ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg   <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!m_tvalid_reg || m_tready) begin
            if (skid_valid_reg) begin
                m_tvalid_reg   <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                m_tvalid_reg <= vq_t;
            end
        end else if (vq_t && en) begin
            // output beat stalled: park the arriving result
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!m_tvalid_reg || m_tready) begin
            if (skid_valid_reg) begin
                m_tdata_reg <= skid_data_reg;
                m_tuser_reg <= skid_status_reg;
            end else begin
                m_tdata_reg <= res_data;
                m_tuser_reg <= tail_t.err;
            end
        end else if (en) begin
            skid_data_reg   <= res_data;
            skid_status_reg <= tail_t.err;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule
